### rtl/pmpp_pkg.sv
// Shared types and constants for the palette match and pixel pack block.
// No dependencies; imported by every module of the block.
package pmpp_pkg;

  // Palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // floor(d/3) for d <= 765 as (d * 683) >> 11
  localparam int DIST_W     = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = 20;

  // Transaction commands
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_CONVERT = 2'd1;
  localparam logic [1:0] CMD_UNPACK  = 2'd2;

  // Configuration register indexes
  localparam logic REG_BPP      = 1'b0;
  localparam logic REG_PALETTED = 1'b1;

  // Supported depths
  localparam logic [7:0] BPP_8  = 8'd8;
  localparam logic [7:0] BPP_15 = 8'd15;
  localparam logic [7:0] BPP_16 = 8'd16;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_RESET = BPP_24;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Scan status back to the controller
  typedef struct packed {
    logic              done;
    logic [PAL_AW-1:0] idx;
    rgb_t              rgb;
  } scan_res_t;

  // Packed / unpacked result fields
  typedef struct packed {
    logic [23:0] color;
    rgb_t        rgb;
    logic        err;
  } pack_res_t;

endpackage

### rtl/palette_match_and_pixel_pack.sv
// Palette match and pixel pack top level. Palette write: no result.
// Unpack or plain convert: result goes through the finish state into the output register;
// next input is taken once back in idle. Paletted convert: scan, then finish state, then output
// register; one palette RAM read per entry. Output hold-off stalls the finish state.
// One transaction in flight; next input taken while a result waits at output.
// Reset: 24 bpp, not paletted; palette reads zero until written (valid bits).
module palette_match_and_pixel_pack
  import pmpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [23:0] color_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] color_out,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        depth_error
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state;
  logic [7:0]        bpp;
  logic              paletted;
  logic              item_unpack;
  logic              item_matched;
  rgb_t              item_rgb;
  logic [23:0]       item_color;

  logic              accept;
  logic              wr_hit;
  logic              scan_start;
  logic              mem_we;
  logic              mem_re;
  logic [PAL_AW-1:0] mem_addr;
  logic [PAL_AW-1:0] scan_addr;
  rgb_t              mem_wdata;
  rgb_t              mem_rdata;
  rgb_t              in_rgb;
  rgb_t              pack_rgb;
  scan_res_t         scan_res;
  pack_res_t         pack_res;
  logic              out_free;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_rgb     = '{r: red_in, g: green_in, b: blue_in};
  assign wr_hit     = (32'(entry_index) < 32'(PAL_ENTRIES));
  assign scan_start = accept && (cmd == CMD_CONVERT) && paletted;
  assign out_free   = !out_valid || out_ready;

  // Palette port: writes only while idle, reads only while scanning
  assign mem_we    = accept && (cmd == CMD_WRITE) && wr_hit;
  assign mem_addr  = mem_we ? PAL_AW'(entry_index) : scan_addr;
  assign mem_wdata = in_rgb;

  pmpp_pal_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pmpp_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .ref_rgb (item_rgb),
    .rd_en   (mem_re),
    .rd_addr (scan_addr),
    .rd_data (mem_rdata),
    .res     (scan_res)
  );

  assign pack_rgb = item_matched ? scan_res.rgb : item_rgb;

  pmpp_pack u_pack (
    .unpack   (item_unpack),
    .bpp      (bpp),
    .paletted (paletted),
    .rgb      (pack_rgb),
    .best_idx (scan_res.idx),
    .color    (item_color),
    .res      (pack_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp      <= BPP_RESET;
      paletted <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BPP:      bpp      <= cfg_data;
        REG_PALETTED: paletted <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Transaction holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_unpack  <= (cmd == CMD_UNPACK);
      item_matched <= (cmd == CMD_CONVERT) && paletted;
      item_rgb     <= in_rgb;
      item_color   <= color_in;
    end
  end

  // Control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (scan_start) begin
              state <= S_SCAN;
            end else if ((cmd == CMD_CONVERT) || (cmd == CMD_UNPACK)) begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      color_out   <= pack_res.color;
      red_out     <= pack_res.rgb.r;
      green_out   <= pack_res.rgb.g;
      blue_out    <= pack_res.rgb.b;
      depth_error <= pack_res.err;
    end
  end

endmodule

### rtl/pmpp_pal_mem.sv
// Palette storage: single-port synchronous RAM, registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses pmpp_pkg.
module pmpp_pal_mem
  import pmpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic              re,
  input  logic [PAL_AW-1:0] addr,
  input  rgb_t              wdata,
  output rgb_t              rdata
);

  rgb_t                   mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] valid;
  rgb_t                   rd_data;
  logic                   rd_valid;

  // Data array, no reset
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[addr];
    end
  end

  // Written-entry flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

### rtl/pmpp_scan.sv
// Nearest-entry scan: one palette read per cycle, distance stage, compare stage.
// Drives the palette read port. Uses pmpp_pkg.
module pmpp_scan
  import pmpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rgb_t              ref_rgb,
  output logic              rd_en,
  output logic [PAL_AW-1:0] rd_addr,
  input  rgb_t              rd_data,
  output scan_res_t         res
);

  localparam logic [PAL_AW-1:0] LAST_ADDR = PAL_AW'(PAL_ENTRIES - 1);

  logic              busy;
  logic              draining;
  logic [PAL_AW-1:0] scan_addr;
  logic              rd_vld;
  logic [PAL_AW-1:0] rd_idx;
  logic              ds_vld;
  logic [PAL_AW-1:0] ds_idx;
  rgb_t              ds_rgb;
  logic [7:0]        ds_dist;
  logic [PAL_AW-1:0] best_idx;
  rgb_t              best_rgb;
  logic [7:0]        best_dist;

  logic [7:0]        dr, dg, db;
  logic [DIST_W-1:0] dsum;
  logic [PROD_W-1:0] prod;
  logic [7:0]        dist3;
  logic              done;

  // Manhattan distance over 3 of the entry just read
  always_comb begin
    dr    = (ref_rgb.r > rd_data.r) ? ref_rgb.r - rd_data.r : rd_data.r - ref_rgb.r;
    dg    = (ref_rgb.g > rd_data.g) ? ref_rgb.g - rd_data.g : rd_data.g - ref_rgb.g;
    db    = (ref_rgb.b > rd_data.b) ? ref_rgb.b - rd_data.b : rd_data.b - ref_rgb.b;
    dsum  = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
    prod  = PROD_W'(dsum) * PROD_W'(DIV3_MUL);
    dist3 = prod[DIV3_SHIFT +: 8];
  end

  assign rd_en   = busy;
  assign rd_addr = scan_addr;
  assign done    = draining && !rd_vld && !ds_vld;

  // Address sequencer and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      draining <= 1'b0;
      rd_vld   <= 1'b0;
      ds_vld   <= 1'b0;
    end else begin
      rd_vld <= busy;
      ds_vld <= rd_vld;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (scan_addr == LAST_ADDR)) begin
        busy     <= 1'b0;
        draining <= 1'b1;
      end
      if (done) begin
        draining <= 1'b0;
      end
    end
  end

  // Address counter and datapath stages
  always_ff @(posedge clk) begin
    if (start) begin
      scan_addr <= '0;
    end else if (busy) begin
      scan_addr <= scan_addr + 1'b1;
    end
    rd_idx  <= scan_addr;
    ds_idx  <= rd_idx;
    ds_rgb  <= rd_data;
    ds_dist <= dist3;
    // entry 0 seeds the best, later ones replace only when strictly closer
    if (ds_vld && ((ds_idx == '0) || (ds_dist < best_dist))) begin
      best_idx  <= ds_idx;
      best_rgb  <= ds_rgb;
      best_dist <= ds_dist;
    end
  end

  assign res.done = done;
  assign res.idx  = best_idx;
  assign res.rgb  = best_rgb;

endmodule

### rtl/pmpp_pack.sv
// Pixel pack for convert and unpack for unpack, by configured depth.
// Pure combinational. Uses pmpp_pkg.
module pmpp_pack
  import pmpp_pkg::*;
(
  input  logic              unpack,
  input  logic [7:0]        bpp,
  input  logic              paletted,
  input  rgb_t              rgb,
  input  logic [PAL_AW-1:0] best_idx,
  input  logic [23:0]       color,
  output pack_res_t         res
);

  always_comb begin
    res = '0;
    if (unpack) begin
      unique case (bpp)
        BPP_15: begin
          res.rgb.r = {color[4:0], 3'b000};
          res.rgb.g = {color[9:5], 3'b000};
          res.rgb.b = {color[14:10], 3'b000};
        end
        BPP_16: begin
          res.rgb.r = {color[4:0], 3'b000};
          res.rgb.g = {color[10:5], 2'b00};
          res.rgb.b = {color[15:11], 3'b000};
        end
        BPP_24: begin
          res.rgb.r = color[7:0];
          res.rgb.g = color[15:8];
          res.rgb.b = color[23:16];
        end
        default: res.err = 1'b1;
      endcase
    end else begin
      unique case (bpp)
        BPP_15: begin
          res.color = {9'd0, rgb.b[7:3], rgb.g[7:3], rgb.r[7:3]};
          res.rgb   = rgb;
        end
        BPP_16: begin
          res.color = {8'd0, rgb.b[7:3], rgb.g[7:2], rgb.r[7:3]};
          res.rgb   = rgb;
        end
        BPP_24: begin
          res.color = {rgb.b, rgb.g, rgb.r};
          res.rgb   = rgb;
        end
        BPP_8: begin
          // index output only makes sense with a palette
          if (paletted) begin
            res.color = 24'(best_idx);
            res.rgb   = rgb;
          end else begin
            res.err = 1'b1;
          end
        end
        default: res.err = 1'b1;
      endcase
    end
  end

endmodule
